[rtl/core/csvtok_pkg.sv]
`timescale 1ns / 1ps

package csvtok_pkg;

  // Input word: one text byte or an end-of-input mark
  typedef struct packed {
    logic [7:0] byte_value;
    logic       input_end;
  } in_word_t;

  // Result word: data byte or field/record end
  typedef struct packed {
    logic [1:0] token_kind;
    logic [7:0] data_byte;
  } out_word_t;

  // Token kinds
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_FIELD  = 2'd1;
  localparam logic [1:0] KIND_RECORD = 2'd2;

  // Fixed byte codes
  localparam logic [7:0] BYTE_NUL = 8'h00;
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_CR  = 8'h0D;

  // Register reset values
  localparam logic [7:0] SEPARATOR_RESET = 8'h2C;
  localparam logic [7:0] QUOTE_RESET     = 8'h22;

  // Register indexes (taken from byte address bit 2)
  localparam logic REG_SEPARATOR = 1'b0;
  localparam logic REG_QUOTE     = 1'b1;

endpackage

[rtl/core/csv_field_tokenizer.sv]
`timescale 1ns / 1ps

// Path: a word accepted on the input is held in the input register, parsed,
//   and, if it makes a token, written to the result register behind out_valid.
// Throughput: one word per clock unless a result waits on out_ready; the
//   parse step is a single phase-register update between the two registers.
// Reset (rst_n low, synchronous): phase returns to record start, both
//   stages empty, separator ',' and quote '"'.
module csv_field_tokenizer (
  input  logic                    clk,
  input  logic                    rst_n,
  // input words
  input  logic                    in_valid,
  output logic                    in_ready,
  input  csvtok_pkg::in_word_t    in_data,
  // result words
  output logic                    out_valid,
  input  logic                    out_ready,
  output csvtok_pkg::out_word_t   out_data,
  // register port
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [2:0]              cfg_paddr,
  input  logic [31:0]             cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);

  // Parse phases
  localparam logic [2:0] PH_RECORD_START = 3'd0;
  localparam logic [2:0] PH_FIELD_START  = 3'd1;
  localparam logic [2:0] PH_PLAIN        = 3'd2;
  localparam logic [2:0] PH_QUOTED       = 3'd3;
  localparam logic [2:0] PH_QUOTE_SEEN   = 3'd4;
  localparam logic [2:0] PH_AFTER_CLOSE  = 3'd5;
  localparam logic [2:0] PH_CR_SEEN      = 3'd6;
  localparam logic [2:0] PH_ENDED        = 3'd7;

  logic [7:0]             sep_r;
  logic [7:0]             quote_r;
  logic [2:0]             phase_r;
  logic [2:0]             phase_nxt;
  logic                   in_valid_r;
  csvtok_pkg::in_word_t   in_word_r;
  logic                   out_valid_r;
  csvtok_pkg::out_word_t  out_word_r;

  logic                   advance;
  logic                   cfg_wr;
  logic [7:0]             b;
  logic                   is_end;
  logic                   hit_quote;
  logic                   hit_sep;
  logic                   hit_lf;
  logic                   hit_cr;
  logic                   delim_hit;
  logic [1:0]             delim_kind;
  logic [2:0]             delim_phase;
  logic [2:0]             eff_phase;
  logic                   emit;
  csvtok_pkg::out_word_t  tok;

  // ---------------------------------------------------------------------
  // Register port: zero-wait APB, byte address bit 2 selects the register
  // ---------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r   <= csvtok_pkg::SEPARATOR_RESET;
      quote_r <= csvtok_pkg::QUOTE_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        csvtok_pkg::REG_SEPARATOR: sep_r   <= cfg_pwdata[7:0];
        csvtok_pkg::REG_QUOTE:     quote_r <= cfg_pwdata[7:0];
        default:                   sep_r   <= sep_r;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = 32'd0;
    unique case (cfg_paddr[2])
      csvtok_pkg::REG_SEPARATOR: cfg_prdata = {24'd0, sep_r};
      csvtok_pkg::REG_QUOTE:     cfg_prdata = {24'd0, quote_r};
      default:                   cfg_prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Handshake: the held word is parsed when the result register is free
  // or is being drained this cycle. A word that makes no token still
  // advances. The input register refills in the same cycle it drains.
  // ---------------------------------------------------------------------
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_word_r <= in_data;
    end
  end

  // ---------------------------------------------------------------------
  // Byte classification. A NUL byte is end of input, and end wins over
  // every register match, so a register holding zero never matches.
  // ---------------------------------------------------------------------
  assign b         = in_word_r.byte_value;
  assign is_end    = in_word_r.input_end || (b == csvtok_pkg::BYTE_NUL);
  assign hit_quote = (b == quote_r);
  assign hit_sep   = (b == sep_r);
  assign hit_lf    = (b == csvtok_pkg::BYTE_LF);
  assign hit_cr    = (b == csvtok_pkg::BYTE_CR);

  // Separator beats LF beats CR when closing a field
  assign delim_hit   = hit_sep || hit_lf || hit_cr;
  assign delim_kind  = hit_sep ? csvtok_pkg::KIND_FIELD : csvtok_pkg::KIND_RECORD;
  assign delim_phase = hit_sep ? PH_FIELD_START :
                       hit_lf  ? PH_RECORD_START : PH_CR_SEEN;

  // After a CR, anything but LF is handled as at record start
  assign eff_phase = (phase_r == PH_CR_SEEN) ? PH_RECORD_START : phase_r;

  // ---------------------------------------------------------------------
  // Parse step
  // ---------------------------------------------------------------------
  always_comb begin
    emit           = 1'b0;
    tok.token_kind = csvtok_pkg::KIND_DATA;
    tok.data_byte  = 8'd0;
    phase_nxt      = phase_r;

    if (phase_r == PH_ENDED) begin
      // drop everything until reset
      phase_nxt = PH_ENDED;
    end else if ((phase_r == PH_CR_SEEN) && !is_end && hit_lf) begin
      // swallow the LF of a CR LF pair
      phase_nxt = PH_RECORD_START;
    end else begin
      unique case (eff_phase)
        PH_RECORD_START, PH_FIELD_START: begin
          if (is_end) begin
            // an empty last field closes only after a separator
            phase_nxt = PH_ENDED;
            if (eff_phase == PH_FIELD_START) begin
              emit           = 1'b1;
              tok.token_kind = csvtok_pkg::KIND_RECORD;
            end
          end else if (hit_quote) begin
            phase_nxt = PH_QUOTED;
          end else if (delim_hit) begin
            emit           = 1'b1;
            tok.token_kind = delim_kind;
            phase_nxt      = delim_phase;
          end else begin
            emit          = 1'b1;
            tok.data_byte = b;
            phase_nxt     = PH_PLAIN;
          end
        end
        PH_PLAIN: begin
          if (is_end) begin
            emit           = 1'b1;
            tok.token_kind = csvtok_pkg::KIND_RECORD;
            phase_nxt      = PH_ENDED;
          end else if (delim_hit) begin
            emit           = 1'b1;
            tok.token_kind = delim_kind;
            phase_nxt      = delim_phase;
          end else begin
            emit          = 1'b1;
            tok.data_byte = b;
          end
        end
        PH_QUOTED: begin
          if (is_end) begin
            emit           = 1'b1;
            tok.token_kind = csvtok_pkg::KIND_RECORD;
            phase_nxt      = PH_ENDED;
          end else if (hit_quote) begin
            phase_nxt = PH_QUOTE_SEEN;
          end else begin
            emit          = 1'b1;
            tok.data_byte = b;
          end
        end
        PH_QUOTE_SEEN, PH_AFTER_CLOSE: begin
          if (is_end) begin
            emit           = 1'b1;
            tok.token_kind = csvtok_pkg::KIND_RECORD;
            phase_nxt      = PH_ENDED;
          end else if ((eff_phase == PH_QUOTE_SEEN) && hit_quote) begin
            // doubled quote inside a quoted field
            emit          = 1'b1;
            tok.data_byte = b;
            phase_nxt     = PH_QUOTED;
          end else if (delim_hit) begin
            emit           = 1'b1;
            tok.token_kind = delim_kind;
            phase_nxt      = delim_phase;
          end else begin
            // drop bytes after the closing quote
            phase_nxt = PH_AFTER_CLOSE;
          end
        end
        default: begin
          phase_nxt = PH_ENDED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RECORD_START;
    end else if (advance) begin
      phase_r <= phase_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_word_r <= tok;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // Field and record ends carry no byte
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_word_r.token_kind != csvtok_pkg::KIND_DATA)
      |-> (out_word_r.data_byte == 8'd0))
    else $error("end token carries a data byte");

  // Token kind never takes the unused code
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_word_r.token_kind != 2'd3))
    else $error("invalid token kind");

  // Once input has ended, no further token appears
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ENDED) && !out_valid_r |=> !out_valid_r)
    else $error("token after end of input");

  // A stalled result blocks a full input register
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("input taken while both stages are blocked");

endmodule
